// File: rtl/ekdsc_pkg.sv
// Package: constants, FSM state type and controller/datapath command structs.
`timescale 1ns / 1ps
package ekdsc_pkg;
	localparam int MAX_LEN_DEF  = 4096;
	localparam int ALPHABET_DEF = 26;
	localparam int LETTER_W     = 5;
	localparam int K_W          = 5;
	localparam int SUM_W        = 24;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ADD,
		ST_TEST,
		ST_DEC,
		ST_SUM,
		ST_FINISH
	} ekdsc_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;    // capture input beat
		logic store_wr;   // write letter into store
		logic set_ovf;    // mark overflow
		logic win_sel;    // 0: at-most-k window, 1: at-most-k-1 window
		logic add;        // count the new letter in the selected window
		logic shrink_dec; // drop the letter read back, advance left
		logic sum;        // accumulate window length
		logic adv_pos;    // advance write position
		logic load_out;   // load the output register
	} ekdsc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic letter_ok;   // letter inside the alphabet
		logic full;        // store is full
		logic need_shrink; // selected window is over its limit
	} ekdsc_stat_t;
endpackage

// File: rtl/ekdsc_if.sv
// Stream interfaces for the input letter beat and the result beat.
`timescale 1ns / 1ps
interface ekdsc_in_if import ekdsc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [LETTER_W-1:0] letter;
	logic                last_letter;
	modport source (output valid, output letter, output last_letter, input ready);
	modport sink (input valid, input letter, input last_letter, output ready);
endinterface

interface ekdsc_out_if import ekdsc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] exact_count;
	logic             string_done;
	logic             overflow;
	modport source (output valid, output exact_count, output string_done, output overflow,
		input ready);
	modport sink (input valid, input exact_count, input string_done, input overflow,
		output ready);
endinterface

// File: rtl/exact_k_distinct_substring_counter_unit.sv
// Top level: counts substrings with exactly k distinct letters, one result per letter.
// Each letter is stored, then counted in the at-most-k window and then in the at-most-k-1
// window: per window an add step, a test step, a store read and count drop per shrink step,
// then a sum step; shrinks amortize to at most one per letter per window.
// Out-of-range or overflow letters go from the check step straight to the result. One letter
// in flight; a stalled result holds the next letter in its final step. Reset: async.
`timescale 1ns / 1ps
module exact_k_distinct_substring_counter_unit import ekdsc_pkg::*; #(
	parameter int MAX_LEN  = MAX_LEN_DEF,
	parameter int ALPHABET = ALPHABET_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [K_W-1:0] cfg_wdata,
	ekdsc_in_if.sink       in_ch,
	ekdsc_out_if.source    out_ch
);
	logic [K_W-1:0] k_q;
	ekdsc_cmd_t     cmd;
	ekdsc_stat_t    stat;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= K_W'(1);
		end else if (cfg_we) begin
			k_q <= cfg_wdata;
		end
	end

	ekdsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_free (!out_ch.valid || out_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ekdsc_dp #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.letter      (in_ch.letter),
		.last_letter (in_ch.last_letter),
		.k_distinct  (k_q),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.exact_count (out_ch.exact_count),
		.string_done (out_ch.string_done),
		.overflow    (out_ch.overflow)
	);
endmodule

// File: rtl/ekdsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ekdsc_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/ekdsc_ctrl.sv
// Controller FSM sequencing store write, window add, shrink and sum steps.
`timescale 1ns / 1ps
module ekdsc_ctrl import ekdsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        out_free,
	input  ekdsc_stat_t stat,
	output ekdsc_cmd_t  cmd
);
	ekdsc_state_t state_q, state_d;
	logic         win_q, win_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			win_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			win_q   <= win_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		win_d       = win_q;
		cmd         = '0;
		cmd.win_sel = win_q;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				win_d = 1'b0;
				if (stat.letter_ok && !stat.full) begin
					cmd.store_wr = 1'b1;
					state_d      = ST_ADD;
				end else begin
					cmd.set_ovf = stat.letter_ok;
					state_d     = ST_FINISH;
				end
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ST_TEST;
			end
			ST_TEST: begin
				// store read at the left index is issued here, data used in ST_DEC
				if (stat.need_shrink) begin
					state_d = ST_DEC;
				end else begin
					state_d = ST_SUM;
				end
			end
			ST_DEC: begin
				cmd.shrink_dec = 1'b1;
				state_d        = ST_TEST;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				if (!win_q) begin
					win_d   = 1'b1;
					state_d = ST_ADD;
				end else begin
					cmd.adv_pos = 1'b1;
					state_d     = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

// File: rtl/ekdsc_dp.sv
// Datapath: letter store, two window count sets, left indexes, sums, output register.
`timescale 1ns / 1ps
module ekdsc_dp import ekdsc_pkg::*; #(
	parameter int MAX_LEN  = MAX_LEN_DEF,
	parameter int ALPHABET = ALPHABET_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [LETTER_W-1:0] letter,
	input  logic                last_letter,
	input  logic [K_W-1:0]      k_distinct,
	input  ekdsc_cmd_t          cmd,
	output ekdsc_stat_t         stat,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [SUM_W-1:0]    exact_count,
	output logic                string_done,
	output logic                overflow
);
	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int LW = $clog2(ALPHABET);
	localparam int DW = $clog2(ALPHABET + 1);

	logic [LETTER_W-1:0] c_q;
	logic                last_q;
	logic [CW-1:0]       wp_q;
	logic                ovf_q;
	logic [CW-1:0]       cnt_q  [2][ALPHABET];
	logic [DW-1:0]       dist_q [2];
	logic [CW-1:0]       left_q [2];
	logic [SUM_W-1:0]    sum_q  [2];
	logic [LETTER_W-1:0] rd_letter;
	logic                w;
	logic [K_W-1:0]      lim;
	logic [LW-1:0]       idx;
	logic [CW-1:0]       cur_cnt;
	logic                x_ok;
	logic                clear;

	assign w = cmd.win_sel;

	ekdsc_ram #(.WIDTH(LETTER_W), .DEPTH(MAX_LEN)) u_store (
		.clk   (clk),
		.we    (cmd.store_wr),
		.waddr (wp_q[AW-1:0]),
		.wdata (c_q),
		.raddr (left_q[w][AW-1:0]),
		.rdata (rd_letter)
	);

	// window limit, count lookup
	always_comb begin
		lim = w ? ((k_distinct == '0) ? '0 : k_distinct - 1'b1) : k_distinct;
		idx = cmd.shrink_dec ? LW'(rd_letter) : LW'(c_q);
		cur_cnt = cnt_q[w][idx];
		x_ok = 32'(rd_letter) < ALPHABET;
		stat.letter_ok   = 32'(c_q) < ALPHABET;
		stat.full        = 32'(wp_q) >= MAX_LEN;
		stat.need_shrink = (32'(dist_q[w]) > 32'(lim)) && (left_q[w] <= wp_q);
	end

	assign clear = cmd.load_out && last_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			c_q    <= letter;
			last_q <= last_letter;
		end
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			ovf_q  <= 1'b0;
			cnt_q  <= '{default: '{default: '0}};
			dist_q <= '{default: '0};
			left_q <= '{default: '0};
			sum_q  <= '{default: '0};
		end else if (clear) begin
			wp_q   <= '0;
			ovf_q  <= 1'b0;
			cnt_q  <= '{default: '{default: '0}};
			dist_q <= '{default: '0};
			left_q <= '{default: '0};
			sum_q  <= '{default: '0};
		end else begin
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.adv_pos) begin
				wp_q <= wp_q + 1'b1;
			end
			if (cmd.add) begin
				cnt_q[w][idx] <= cur_cnt + 1'b1;
				if (cur_cnt == '0) begin
					dist_q[w] <= dist_q[w] + 1'b1;
				end
			end
			if (cmd.shrink_dec) begin
				left_q[w] <= left_q[w] + 1'b1;
				if (x_ok && cur_cnt != '0) begin
					cnt_q[w][idx] <= cur_cnt - 1'b1;
					if (cur_cnt == CW'(1)) begin
						dist_q[w] <= dist_q[w] - 1'b1;
					end
				end
			end
			if (cmd.sum) begin
				sum_q[w] <= sum_q[w] + SUM_W'(wp_q + 1'b1 - left_q[w]);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			exact_count <= sum_q[0] - sum_q[1];
			string_done <= last_q;
			overflow    <= ovf_q;
		end
	end
endmodule

// File: tb/sv/tb_exact_k_distinct_substring_counter_unit.sv
// Testbench: random and directed letter strings, checked against a window-count predictor.
`timescale 1ns / 1ps
module tb_exact_k_distinct_substring_counter_unit;
	import ekdsc_pkg::*;

	localparam int STORE_DEPTH = 1024;
	localparam int NUM_LETTERS = ALPHABET_DEF;
	localparam int IDLE_LIMIT  = 100000;
	localparam int DRAIN_WAIT  = 40;
	localparam int WIN_K       = 0;
	localparam int WIN_KM1     = 1;

	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic                last_letter;
	} letter_beat_t;

	typedef struct packed {
		logic [SUM_W-1:0] exact_count;
		logic             string_done;
		logic             overflow;
	} count_beat_t;

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	logic [K_W-1:0] cfg_wdata;

	ekdsc_in_if  in_bus ();
	ekdsc_out_if out_bus ();

	exact_k_distinct_substring_counter_unit #(.MAX_LEN(STORE_DEPTH)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_bus),
		.out_ch    (out_bus)
	);

	letter_beat_t letters_pending[$];
	count_beat_t  counts_expected[$];
	int           fail_count;
	int           idle_cycles;

	// predictor state: one slot per window (at most k, at most k-1)
	logic [LETTER_W-1:0] pred_store[STORE_DEPTH];
	int                  pred_counts[2][NUM_LETTERS];
	int                  pred_distinct[2];
	int                  pred_left[2];
	logic [SUM_W-1:0]    pred_sum[2];
	int                  pred_wpos;
	bit                  pred_ovf;
	logic [K_W-1:0]      pred_k;

	// source pacing
	int burst_left;
	int gap_left;
	// sink stall pattern
	int stall_mode;
	int stall_phase;

	always #1 clk = ~clk;

	function automatic void clear_windows();
		for (int w = 0; w < 2; w++) begin
			for (int c = 0; c < NUM_LETTERS; c++) pred_counts[w][c] = 0;
			pred_distinct[w] = 0;
			pred_left[w]     = 0;
			pred_sum[w]      = '0;
		end
		pred_wpos = 0;
		pred_ovf  = 0;
	endfunction

	// count a new letter in one window, shrink from the left while over the limit
	function automatic void window_take(int w, int c, int pos, int lim);
		int x;
		if (pred_counts[w][c] == 0) pred_distinct[w]++;
		pred_counts[w][c]++;
		while (pred_distinct[w] > lim && pred_left[w] <= pos) begin
			x = pred_store[pred_left[w] % STORE_DEPTH];
			if (x < NUM_LETTERS && pred_counts[w][x] != 0) begin
				pred_counts[w][x]--;
				if (pred_counts[w][x] == 0) pred_distinct[w]--;
			end
			pred_left[w]++;
		end
		pred_sum[w] = pred_sum[w] + SUM_W'(pos + 1 - pred_left[w]);
	endfunction

	function automatic count_beat_t count_after(letter_beat_t b);
		count_beat_t r;
		int lim;
		if (b.letter < NUM_LETTERS) begin
			if (pred_wpos >= STORE_DEPTH) begin
				pred_ovf = 1;
			end else begin
				lim = pred_k;
				pred_store[pred_wpos] = b.letter;
				window_take(WIN_K, b.letter, pred_wpos, lim);
				window_take(WIN_KM1, b.letter, pred_wpos, (lim == 0) ? 0 : lim - 1);
				pred_wpos++;
			end
		end
		r.exact_count = pred_sum[WIN_K] - pred_sum[WIN_KM1];
		r.string_done = b.last_letter;
		r.overflow    = pred_ovf;
		if (b.last_letter) clear_windows();
		return r;
	endfunction

	// queue a string of letters drawn from a window of the alphabet, some out of range
	task automatic queue_string(int len, int span, int noise_pct, bit close_it);
		letter_beat_t b;
		int base;
		base = $urandom_range(0, NUM_LETTERS - span);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				b.letter = LETTER_W'($urandom_range(NUM_LETTERS, 31));
			else
				b.letter = LETTER_W'(base + $urandom_range(0, span - 1));
			b.last_letter = close_it && (i == len - 1);
			letters_pending.push_back(b);
		end
	endtask

	task automatic queue_letter(int l, bit last);
		letter_beat_t b;
		b.letter      = LETTER_W'(l);
		b.last_letter = last;
		letters_pending.push_back(b);
	endtask

	task automatic wait_idle();
		while (letters_pending.size() != 0 || counts_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_k(int k);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= K_W'(k);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// drive source beats at the falling edge
	always @(negedge clk) begin
		if (!arst_n || gap_left > 0 || letters_pending.size() == 0) begin
			in_bus.valid <= 1'b0;
		end else begin
			in_bus.valid       <= 1'b1;
			in_bus.letter      <= letters_pending[0].letter;
			in_bus.last_letter <= letters_pending[0].last_letter;
		end
		if (gap_left > 0 && arst_n) gap_left--;
		// sink stall pattern, chosen at random among four modes
		stall_phase++;
		if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_bus.ready <= 1'b1;
			1: out_bus.ready <= 1'($urandom_range(0, 1));
			2: out_bus.ready <= (stall_phase % 4 == 0);
			default: out_bus.ready <= ((stall_phase / 8) % 2 == 0);
		endcase
	end

	// sample beats, predict and compare at the rising edge
	always @(posedge clk) begin
		count_beat_t got;
		count_beat_t want;
		if (arst_n) begin
			if (cfg_we) pred_k = cfg_wdata;
			idle_cycles++;
			if (out_bus.valid && out_bus.ready) begin
				idle_cycles = 0;
				got.exact_count = out_bus.exact_count;
				got.string_done = out_bus.string_done;
				got.overflow    = out_bus.overflow;
				if (counts_expected.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, got);
					fail_count++;
				end else begin
					want = counts_expected.pop_front();
					if (got.exact_count !== want.exact_count) begin
						$display("%0t: exact_count expected %0d actual %0d", $time,
							want.exact_count, got.exact_count);
						fail_count++;
					end
					if (got.string_done !== want.string_done) begin
						$display("%0t: string_done expected %0b actual %0b", $time,
							want.string_done, got.string_done);
						fail_count++;
					end
					if (got.overflow !== want.overflow) begin
						$display("%0t: overflow expected %0b actual %0b", $time,
							want.overflow, got.overflow);
						fail_count++;
					end
				end
			end
			if (in_bus.valid && in_bus.ready) begin
				idle_cycles = 0;
				counts_expected.push_back(count_after(letters_pending.pop_front()));
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** exact_k_distinct_substring_counter_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int k_choices[8];
		clk = 0; arst_n = 0; cfg_we = 0; cfg_wdata = '0;
		in_bus.valid = 0; in_bus.letter = '0; in_bus.last_letter = 0;
		out_bus.ready = 0;
		fail_count = 0; idle_cycles = 0;
		burst_left = 5; gap_left = 0; stall_mode = 0; stall_phase = 0;
		pred_k = 1;
		clear_windows();
		repeat (3) @(negedge clk);
		arst_n = 1;

		// directed: reset k of 1, alphabet edges, out-of-range letters, one-letter string
		queue_letter(0, 0); queue_letter(0, 0); queue_letter(25, 0);
		queue_letter(26, 0); queue_letter(31, 0); queue_letter(25, 1);
		queue_letter(7, 1);
		queue_letter(30, 1);
		wait_idle();
		write_k(2);
		queue_letter(0, 0); queue_letter(1, 0); queue_letter(0, 0);
		queue_letter(2, 0); queue_letter(2, 0);
		wait_idle();
		// k changed in the middle of a string
		write_k(1);
		queue_letter(3, 0); queue_letter(3, 0); queue_letter(4, 1);
		wait_idle();
		write_k(0);
		queue_string(6, 4, 0, 1);
		wait_idle();
		write_k(26);
		queue_string(6, 26, 0, 1);
		wait_idle();
		write_k(31);
		queue_string(5, 26, 0, 1);
		wait_idle();

		// long string past the store depth
		write_k($urandom_range(1, 4));
		queue_string(STORE_DEPTH + 8, 6, 2, 1);
		wait_idle();

		// random phases, k extremes among them; some phases end mid-string
		k_choices = '{0, 1, 2, 3, 5, 26, 27, 31};
		for (int p = 0; p < 21; p++) begin
			if ($urandom_range(0, 1))
				write_k(k_choices[$urandom_range(0, 7)]);
			else
				write_k($urandom_range(0, 31));
			for (int s = 0; s < 4; s++)
				queue_string($urandom_range(1, 20), $urandom_range(1, 26),
					($urandom_range(0, 3) == 0) ? 15 : 0, (s < 3) || $urandom_range(0, 1));
			wait_idle();
		end

		if (fail_count == 0)
			$display("** exact_k_distinct_substring_counter_unit: PASSED **");
		else
			$display("** exact_k_distinct_substring_counter_unit: FAILED **");
		$finish;
	end
endmodule

// File: filelist.f
rtl/ekdsc_pkg.sv
rtl/ekdsc_if.sv
rtl/ekdsc_ram.sv
rtl/ekdsc_ctrl.sv
rtl/ekdsc_dp.sv
rtl/exact_k_distinct_substring_counter_unit.sv
tb/sv/tb_exact_k_distinct_substring_counter_unit.sv
